FILE: rtl/core/c_keyword_lexer_assert.svh
// assertion macros for the c keyword lexer
// expects clk_i and rst_ni in the scope of each use
`ifndef C_KEYWORD_LEXER_ASSERT_SVH
`define C_KEYWORD_LEXER_ASSERT_SVH

// same-cycle implication
`define CKL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ckl_pkg.sv
// shared types, constants and keyword table of the c keyword lexer
// no dependencies
package ckl_pkg;

  localparam int KW_MAX_LEN  = 8;
  localparam int ROW_W       = 20;
  localparam int COL_W       = 16;
  localparam int LEN_W       = 16;
  localparam int KIND_W      = 6;
  localparam int KW_BITS     = 8 * KW_MAX_LEN;
  localparam int KW_IDX_W    = $clog2(KW_MAX_LEN);
  localparam int KW_COUNT    = 34;
  localparam int OP_COUNT    = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 6'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 6'd1;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd2;
  localparam logic [KIND_W-1:0] KIND_INT     = 6'd3;
  localparam logic [KIND_W-1:0] KIND_OP_BASE = 6'd4;
  localparam logic [KIND_W-1:0] KIND_KW_BASE = 6'd13;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0a;

  localparam logic [7:0] OP_CHARS [OP_COUNT] = '{"=", "+", "-", "(", ")", "<", ">", "*", "/"};

  // right-aligned keyword text, zero above
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
    "unsigned", "void", "volatile", "while"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6,
    4'd5, 4'd3, 4'd4, 4'd2, 4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
  };

  // one queue entry: everything one input item produces
  typedef struct packed {
    logic                run_vld;
    logic                run_word;
    logic [ROW_W-1:0]    run_row;
    logic [COL_W-1:0]    run_col;
    logic [LEN_W-1:0]    run_len;
    logic [KW_BITS-1:0]  run_text;
    logic                sng_vld;
    logic [KIND_W-1:0]   sng_kind;
    logic [ROW_W-1:0]    sng_row;
    logic [COL_W-1:0]    sng_col;
    logic [7:0]          sng_char;
  } tok_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [KIND_W-1:0] op_kind(logic [7:0] c);
    logic [KIND_W-1:0] kind;
    kind = KIND_ILLEGAL;
    for (int i = 0; i < OP_COUNT; i++) begin
      if (c == OP_CHARS[i]) begin
        kind = KIND_OP_BASE + KIND_W'(i);
      end
    end
    return kind;
  endfunction

  // text holds the first bytes of the run, first byte at the top
  function automatic logic [KIND_W-1:0] word_kind(logic [KW_BITS-1:0] text,
                                                  logic [LEN_W-1:0] len);
    logic [KW_BITS-1:0] rj;
    logic [KIND_W-1:0]  kind;
    kind = KIND_IDENT;
    rj   = '0;
    if (len <= LEN_W'(KW_MAX_LEN)) begin
      rj = text >> (8 * (KW_MAX_LEN - int'(len)));
      for (int i = 0; i < KW_COUNT; i++) begin
        if (LEN_W'(KW_LEN[i]) == len && rj == KW_TEXT[i]) begin
          kind = KIND_KW_BASE + KIND_W'(i);
        end
      end
    end
    return kind;
  endfunction

endpackage

FILE: rtl/core/ckl_if.sv
// valid/ready channel interfaces of the c keyword lexer
// depends on ckl_pkg
interface ckl_in_if;
  import ckl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       at_end;
  modport source (output valid, output char_byte, output at_end, input ready);
  modport sink   (input valid, input char_byte, input at_end, output ready);
endinterface

interface ckl_out_if;
  import ckl_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [ROW_W-1:0]  token_row;
  logic [COL_W-1:0]  token_col;
  logic [LEN_W-1:0]  token_length;
  logic [7:0]        token_char;
  logic              last_of_run;
  modport source (output valid, output token_kind, output token_row, output token_col,
                  output token_length, output token_char, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_row, input token_col,
                  input token_length, input token_char, input last_of_run,
                  output ready);
endinterface

FILE: rtl/core/ckl_front.sv
// front end: scan state, position counters and word buffer
// depends on ckl_pkg and ckl_in_if
module ckl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ckl_in_if.sink          in_i,
  input  ckl_pkg::q_stat_t q_stat_i,
  output logic            push_o,
  output ckl_pkg::tok_rec_t rec_o
);
  import ckl_pkg::*;

  logic [1:0]         mode_q, mode_d;
  logic [ROW_W-1:0]   line_q, line_d, line_nx;
  logic [COL_W-1:0]   col_q, col_d, col_nx;
  logic [ROW_W-1:0]   srow_q, srow_d;
  logic [COL_W-1:0]   scol_q, scol_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [KW_BITS-1:0] text_q, text_d;
  logic [7:0]         c;
  logic               acc, is_letter, is_digit, is_space, cont;
  tok_rec_t           rec;

  assign in_i.ready = !q_stat_i.full;
  assign acc        = in_i.valid && in_i.ready;
  assign c          = in_i.char_byte;

  assign is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit  = c >= "0" && c <= "9";
  assign is_space  = c == " " || (c >= 8'd9 && c <= 8'd13);
  assign cont      = (mode_q == MODE_WORD && is_letter) || (mode_q == MODE_NUM && is_digit);

  assign line_nx = (c == CHAR_NL) ? ((&line_q) ? line_q : line_q + 1'b1) : line_q;
  assign col_nx  = (c == CHAR_NL) ? '0 : ((&col_q) ? col_q : col_q + 1'b1);

  always_comb begin
    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    srow_d = srow_q;
    scol_d = scol_q;
    len_d  = len_q;
    text_d = text_q;

    rec          = '0;
    rec.run_word = mode_q == MODE_WORD;
    rec.run_row  = srow_q;
    rec.run_col  = scol_q;
    rec.run_len  = len_q;
    rec.run_text = text_q;
    rec.sng_kind = op_kind(c);
    rec.sng_row  = line_nx;
    rec.sng_col  = col_nx;
    rec.sng_char = c;

    if (acc) begin
      if (in_i.at_end) begin
        rec.run_vld  = mode_q != MODE_IDLE;
        rec.sng_vld  = 1'b1;
        rec.sng_kind = KIND_END;
        rec.sng_row  = line_q;
        rec.sng_col  = (&col_q) ? col_q : col_q + 1'b1;
        rec.sng_char = '0;
        mode_d       = MODE_IDLE;
        line_d       = ROW_W'(1);
        col_d        = '0;
      end else begin
        line_d = line_nx;
        col_d  = col_nx;
        if (cont) begin
          len_d = (&len_q) ? len_q : len_q + 1'b1;
          if (mode_q == MODE_WORD && len_q < LEN_W'(KW_MAX_LEN)) begin
            for (int i = 0; i < KW_MAX_LEN; i++) begin
              if (len_q[KW_IDX_W-1:0] == KW_IDX_W'(i)) begin
                text_d[KW_BITS-1-8*i -: 8] = c;
              end
            end
          end
        end else begin
          rec.run_vld = mode_q != MODE_IDLE;
          mode_d      = MODE_IDLE;
          if (is_letter || is_digit) begin
            mode_d                = is_letter ? MODE_WORD : MODE_NUM;
            srow_d                = line_nx;
            scol_d                = col_nx;
            len_d                 = LEN_W'(1);
            text_d[KW_BITS-1 -: 8] = c;
          end else if (!is_space) begin
            rec.sng_vld = 1'b1;
          end
        end
      end
    end
  end

  assign push_o = acc && (rec.run_vld || rec.sng_vld);
  assign rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= ROW_W'(1);
      col_q  <= '0;
      srow_q <= '0;
      scol_q <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      srow_q <= srow_d;
      scol_q <= scol_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_q <= text_d;
  end

endmodule

FILE: rtl/core/ckl_queue.sv
// short queue of per-item token records between front and back
// depends on ckl_pkg
module ckl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ckl_pkg::tok_rec_t rec_i,
  input  logic              pop_i,
  output ckl_pkg::tok_rec_t head_o,
  output ckl_pkg::q_stat_t  stat_o
);
  import ckl_pkg::*;

  tok_rec_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

FILE: rtl/core/ckl_back.sv
// back end: keyword lookup, splits records into tokens, output register
// depends on ckl_pkg and ckl_out_if
module ckl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ckl_pkg::tok_rec_t head_i,
  input  ckl_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  ckl_out_if.source         out_o
);
  import ckl_pkg::*;

  logic              second_q, second_d;
  logic              vld_q, vld_d;
  logic              load, take_run, last;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;

  assign load     = !q_stat_i.empty && (!vld_q || out_o.ready);
  assign take_run = !second_q && head_i.run_vld;
  assign last     = !take_run || !head_i.sng_vld;
  assign pop_o    = load && last;

  always_comb begin
    second_d = second_q;
    vld_d    = vld_q && !out_o.ready;
    kind_d   = kind_q;
    row_d    = row_q;
    col_d    = col_q;
    len_d    = len_q;
    char_d   = char_q;
    last_d   = last_q;
    if (load) begin
      vld_d    = 1'b1;
      second_d = !last;
      last_d   = last;
      if (take_run) begin
        kind_d = head_i.run_word ? word_kind(head_i.run_text, head_i.run_len) : KIND_INT;
        row_d  = head_i.run_row;
        col_d  = head_i.run_col;
        len_d  = head_i.run_len;
        char_d = '0;
      end else begin
        kind_d = head_i.sng_kind;
        row_d  = head_i.sng_row;
        col_d  = head_i.sng_col;
        len_d  = (head_i.sng_kind == KIND_END) ? '0 : LEN_W'(1);
        char_d = head_i.sng_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    row_q  <= row_d;
    col_q  <= col_d;
    len_q  <= len_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid        = vld_q;
  assign out_o.token_kind   = kind_q;
  assign out_o.token_row    = row_q;
  assign out_o.token_col    = col_q;
  assign out_o.token_length = len_q;
  assign out_o.token_char   = char_q;
  assign out_o.last_of_run  = last_q;

endmodule

FILE: rtl/core/c_keyword_lexer.sv
// c keyword lexer: streaming tokenizer of c source bytes
// top level; depends on ckl_pkg, ckl_if, ckl_front, ckl_queue, ckl_back
//
// usage:
// - in_i takes one source byte per item (char_byte) with at_end; an item
//   with at_end set closes any open run, emits an end token and restarts
//   the row and column counters
// - out_o gives one token per item: kind, start row and column, length,
//   character, and last_of_run on the final token of each input item
// - an input item yields zero, one or two tokens
// - throughput: one input item per cycle while the queue is not full; the
//   output register sends one token per cycle while the receiver is ready,
//   so the two tokens of an item leave one after the other; a taken item is
//   written to the queue, then its tokens are loaded into the output register
// - a four-entry record queue sits between front and back; the front
//   keeps taking items while the receiver stalls, until the queue is full
// - reset clears the scan state, sets the row to one and empties the queue
module c_keyword_lexer (
  input logic       clk_i,
  input logic       rst_ni,
  ckl_in_if.sink    in_i,
  ckl_out_if.source out_o
);
  import ckl_pkg::*;

  `include "c_keyword_lexer_assert.svh"

  tok_rec_t fr_rec, q_head;
  q_stat_t  q_stat;
  logic     q_push, q_pop, in_acc;

  ckl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .rec_o    (fr_rec)
  );

  ckl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (fr_rec),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  ckl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

  assign in_acc = in_i.valid && in_i.ready;

  `CKL_ASSERT_NOW(a_end_pushes, in_acc && in_i.at_end, q_push, "end item wrote no record")
  `CKL_ASSERT_NOW(a_full_stalls, q_stat.full, !in_i.ready, "input ready with full queue")
  `CKL_ASSERT_NEXT(a_pop_frees, q_stat.full && q_pop, !q_stat.full, "pop left queue full")

endmodule
